>>> rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] NONE_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] push_value;
    } deq_req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic [4:0]         entry_count;
        logic               is_empty;
    } deq_rsp_t;

endpackage

`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
`default_nettype none

// Double-ended queue of signed 32-bit words held in a ring buffer of DEPTH entries in one
// synchronous RAM (one write, one read per cycle, registered read data). Each request word
// pushes at the front or rear or pops from the front or rear and gives exactly one response
// word with the popped value, a status, the front and rear entries after the step, the
// entry count and an empty flag. The current front and rear entries are kept in registers,
// so a push, a push into a full queue or a pop from an empty queue goes straight into the
// response register; a pop first reads the entry that becomes the new front or rear from
// the RAM into its read data register and answers from S_POP. A new request is taken while
// the previous response still waits, unless that response is stalled or a pop is in flight.
// RAM contents are not cleared at reset; data from empty entries never reaches a response.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire deq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output deq_rsp_t      rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    logic signed [31:0] mem [DEPTH];

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] front_reg, front_next;
    logic signed [31:0] rear_reg, rear_next;
    logic               pend_front_reg, pend_front_next;
    logic               rsp_valid_reg, rsp_valid_next;
    deq_rsp_t           rsp_reg, rsp_next;
    logic signed [31:0] rd_data_reg;

    logic               accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      head_dec;
    logic [SW-1:0]      tail_sum;
    logic [AW-1:0]      tail_pos;
    logic [SW-1:0]      prev_sum;
    logic [AW-1:0]      prev_pos;
    logic signed [31:0] new_front;
    logic signed [31:0] new_rear;

    function automatic deq_rsp_t make_rsp(input logic signed [31:0] popped,
                                          input logic [1:0] st,
                                          input logic signed [31:0] front,
                                          input logic signed [31:0] rear,
                                          input logic [CW-1:0] count);
        deq_rsp_t r;
        r.popped_value = popped;
        r.status       = st;
        r.front_value  = (count == '0) ? NONE_VALUE : front;
        r.rear_value   = (count == '0) ? NONE_VALUE : rear;
        r.entry_count  = 5'(count);
        r.is_empty     = (count == '0);
        return r;
    endfunction

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg == S_POP) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - AW'(1);

    // ring position one past the rear
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

    // entry just before the rear, only meaningful with two or more entries
    assign prev_sum = tail_sum - SW'(2);
    assign prev_pos = (count_reg < CW'(2)) ? head_reg :
                      (prev_sum >= DEPTH_S) ? AW'(prev_sum - DEPTH_S) : AW'(prev_sum);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        pend_front_next = pend_front_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_pos;
        rd_addr         = (req.req_type == REQ_POP_REAR) ? prev_pos : head_inc;
        new_front       = front_reg;
        new_rear        = rear_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_REAR:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                rsp_next = make_rsp('0, ST_FULL, front_reg, rear_reg, count_reg);
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (req.req_type == REQ_PUSH_FRONT)
                                begin
                                    wr_addr   = head_dec;
                                    head_next = head_dec;
                                    new_front = req.push_value;
                                    if (count_reg == '0)
                                    begin
                                        new_rear = req.push_value;
                                    end
                                end
                                else
                                begin
                                    new_rear = req.push_value;
                                    if (count_reg == '0)
                                    begin
                                        new_front = req.push_value;
                                    end
                                end
                                front_next = new_front;
                                rear_next  = new_rear;
                                rsp_next   = make_rsp('0, ST_OK, new_front, new_rear,
                                                      count_next);
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = make_rsp(NONE_VALUE, ST_EMPTY, front_reg,
                                                          rear_reg, count_reg);
                            end
                            else
                            begin
                                // neighbor entry is read into rd_data_reg now, the response is made in S_POP
                                state_next      = S_POP;
                                count_next      = count_reg - CW'(1);
                                pend_front_next = (req.req_type == REQ_POP_FRONT);
                                if (req.req_type == REQ_POP_FRONT)
                                begin
                                    head_next = head_inc;
                                end
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (pend_front_reg)
                begin
                    new_front = rd_data_reg;
                end
                else
                begin
                    new_rear = rd_data_reg;
                end
                front_next     = new_front;
                rear_next      = new_rear;
                rsp_valid_next = 1'b1;
                rsp_next       = make_rsp(pend_front_reg ? front_reg : rear_reg, ST_OK,
                                          new_front, new_rear, count_reg);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_POS)
        else $error("head position outside ring");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("pop did not complete in one cycle");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_REAR)
        && count_reg != DEPTH_C |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not add one entry");
`endif

endmodule

`default_nettype wire

>>> tb/deq_response_checker.sv
`timescale 1ns / 1ps

module deq_response_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_stall,
    input  wire deq_req_t req,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_stall,
    input  wire deq_rsp_t rsp,
    output int            mismatch_count,
    output int            pending_count
);

    logic signed [31:0] shadow_store [DEPTH];
    int                 shadow_head;
    int                 shadow_count;
    deq_rsp_t           expected_rsp_q [$];
    deq_rsp_t           want;
    int                 errs;
    logic               bad;

    // applies one request word to the shadow deque and gives the response it should cause
    function automatic deq_rsp_t deque_next_response(deq_req_t r);
        deq_rsp_t o;
        o.popped_value = '0;
        o.status       = ST_OK;
        o.front_value  = NONE_VALUE;
        o.rear_value   = NONE_VALUE;
        case (r.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (shadow_count >= DEPTH)
                    o.status = ST_FULL;
                else if (r.req_type == REQ_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_store[shadow_head] = r.push_value;
                    shadow_count++;
                end
                else
                begin
                    shadow_store[(shadow_head + shadow_count) % DEPTH] = r.push_value;
                    shadow_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (shadow_count == 0)
                begin
                    o.status       = ST_EMPTY;
                    o.popped_value = NONE_VALUE;
                end
                else if (r.req_type == REQ_POP_FRONT)
                begin
                    o.popped_value = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
                else
                begin
                    o.popped_value = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            end
            default:
            begin
                o.status = ST_OK;
            end
        endcase
        if (shadow_count != 0)
        begin
            o.front_value = shadow_store[shadow_head];
            o.rear_value  = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
        end
        o.entry_count = 5'(shadow_count);
        o.is_empty    = (shadow_count == 0);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rsp_q.delete();
            shadow_head  = 0;
            shadow_count = 0;
            pending_count <= 0;
        end
        else
        begin
            // a request and a response on the same edge: queue first, oldest is compared
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(deque_next_response(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected response word: popped %0d status %0d count %0d",
                                 rsp.popped_value, rsp.status, rsp.entry_count);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    bad  = (rsp.popped_value !== want.popped_value)
                        || (rsp.status       !== want.status)
                        || (rsp.front_value  !== want.front_value)
                        || (rsp.rear_value   !== want.rear_value)
                        || (rsp.entry_count  !== want.entry_count)
                        || (rsp.is_empty     !== want.is_empty);
                    if (bad)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $write("mismatch exp: popped %0d status %0d front %0d",
                                   want.popped_value, want.status, want.front_value);
                            $display(" rear %0d count %0d empty %0b",
                                     want.rear_value, want.entry_count, want.is_empty);
                            $write("         got: popped %0d status %0d front %0d",
                                   rsp.popped_value, rsp.status, rsp.front_value);
                            $display(" rear %0d count %0d empty %0b",
                                     rsp.rear_value, rsp.entry_count, rsp.is_empty);
                        end
                    end
                end
            end
            pending_count <= expected_rsp_q.size();
        end
        mismatch_count <= errs;
    end

endmodule

>>> tb/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
    import deq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 450;
    localparam int CYCLE_LIMIT  = 200000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    deq_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    deq_rsp_t rsp;
    int       mismatch_count;
    int       pending_count;
    int       cycle_count;

    double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    deq_response_checker #(.DEPTH(DEPTH)) resp_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly full-range random, sometimes the edge values
    function automatic logic signed [31:0] random_push_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return NONE_VALUE;
            default: return $urandom;
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that accepts the word
    task automatic send_word(input logic [1:0] kind, input logic signed [31:0] value,
                             input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid       <= 1'b1;
        req.req_type    <= kind;
        req.push_value  <= value;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // response side: random stalls, a long hold-off, then more random hold-offs
    initial
    begin : rsp_side
        int held;
        int hold_len;
        int stall_pct;
        int span;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        repeat (300)
        begin
            @(posedge clk);
            rsp_stall <= ($urandom_range(0, 3) == 0);
        end
        @(posedge clk);
        rsp_stall <= 1'b1;
        for (held = 0; held < 160; held++)
            @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                default: stall_pct = 70;
            endcase
            span = $urandom_range(16, 64);
            repeat (span)
            begin
                @(posedge clk);
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                @(posedge clk);
                rsp_stall <= 1'b1;
                hold_len = $urandom_range(20, 60);
                for (held = 0; held < hold_len; held++)
                    @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : req_side
        int  n;
        int  k;
        int  i;
        int  mode;
        int  burst;
        int  push_pct;
        bit  quiet;
        bit  is_push;
        logic [1:0] kind;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty deque
        send_word(REQ_POP_FRONT, 32'sd5, 0);
        send_word(REQ_POP_REAR, 32'sd5, 1);
        // extremes through both ends
        send_word(REQ_PUSH_FRONT, 32'sh8000_0000, 0);
        send_word(REQ_PUSH_REAR, 32'sh7fff_ffff, 0);
        send_word(REQ_POP_FRONT, 32'sd0, 0);
        send_word(REQ_POP_REAR, 32'sd0, 2);
        // fill to capacity, then pushes are refused at either end
        for (i = 0; i < DEPTH; i++)
            send_word(i[0] ? REQ_PUSH_REAR : REQ_PUSH_FRONT,
                      (i == 3) ? NONE_VALUE : (i == 5) ? 32'sd0 : random_push_value(), 0);
        send_word(REQ_PUSH_FRONT, 32'sh1234_5678, 0);
        send_word(REQ_PUSH_REAR, 32'sh7fff_ffff, 0);
        send_word(REQ_POP_REAR, 32'sd0, 0);
        send_word(REQ_POP_FRONT, 32'sd0, 0);

        // bursts that drift toward full or empty with random content
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
            case (mode)
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            for (k = 0; k < burst && n < RANDOM_WORDS; k++)
            begin
                is_push = ($urandom_range(0, 99) < push_pct);
                if (is_push)
                    kind = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
                send_word(kind, random_push_value(), quiet ? 0 : pick_gap());
                n++;
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
